// File: src/hrsd_pkg.sv
package hrsd_pkg;

    localparam int COLOR_W    = 3;
    localparam int ROW_ADDR_W = 4;

    // operation codes of an input item
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // refresh sequence, one code per pin-level step
    typedef enum logic [7:0] {
        PH_DRIVE    = 8'b0000_0001,
        PH_CLK_HI   = 8'b0000_0010,
        PH_CLK_LO   = 8'b0000_0100,
        PH_HOLD     = 8'b0000_1000,
        PH_LATCH_HI = 8'b0001_0000,
        PH_LATCH_LO = 8'b0010_0000,
        PH_OE_LO    = 8'b0100_0000,
        PH_OE_HI    = 8'b1000_0000
    } phase_t;

    // control pin levels after one step, plus the colour reload flag
    typedef struct packed {
        logic                  load_colours;
        logic                  shift_clock;
        logic                  latch_strobe;
        logic                  output_enable_n;
        logic [ROW_ADDR_W-1:0] row_address;
    } scan_step_t;

endpackage

// File: src/hrsd_if.sv
interface hrsd_cfg_if;
    logic valid;
    logic ready;
    logic refresh_enable;

    modport source (output valid, output refresh_enable, input ready);
    modport sink (input valid, input refresh_enable, output ready);
endinterface

interface hrsd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [4:0] pixel_row;
    logic [5:0] pixel_column;
    logic       red_on;
    logic       green_on;
    logic       blue_on;

    modport source (
        output valid, output operation, output pixel_row, output pixel_column,
        output red_on, output green_on, output blue_on, input ready
    );
    modport sink (
        input valid, input operation, input pixel_row, input pixel_column,
        input red_on, input green_on, input blue_on, output ready
    );
endinterface

interface hrsd_out_if;
    logic       valid;
    logic       ready;
    logic       red_top;
    logic       green_top;
    logic       blue_top;
    logic       red_bottom;
    logic       green_bottom;
    logic       blue_bottom;
    logic       shift_clock;
    logic       latch_strobe;
    logic       output_enable_n;
    logic [3:0] row_address;

    modport source (
        output valid, output red_top, output green_top, output blue_top,
        output red_bottom, output green_bottom, output blue_bottom,
        output shift_clock, output latch_strobe, output output_enable_n,
        output row_address, input ready
    );
    modport sink (
        input valid, input red_top, input green_top, input blue_top,
        input red_bottom, input green_bottom, input blue_bottom,
        input shift_clock, input latch_strobe, input output_enable_n,
        input row_address, output ready
    );
endinterface

// File: src/hrsd_frame_ram.sv
module hrsd_frame_ram #(
    parameter int AW = 10
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [hrsd_pkg::COLOR_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [hrsd_pkg::COLOR_W-1:0] rd_data
);

    logic [hrsd_pkg::COLOR_W-1:0] frame_mem [2**AW];
    logic [hrsd_pkg::COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/hrsd_scan_ctrl.sv
module hrsd_scan_ctrl #(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 32,
    localparam int HALF   = ROWS / 2,
    localparam int RW     = $clog2(HALF),
    localparam int CW     = $clog2(COLUMNS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    output hrsd_pkg::scan_step_t step,
    output logic [RW-1:0]        rd_row,
    output logic [CW-1:0]        rd_column
);

    localparam int RA_W = hrsd_pkg::ROW_ADDR_W;

    hrsd_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    column_reg, column_next;
    logic [RW-1:0]    row_reg, row_next;
    logic             clock_reg, clock_next;
    logic             latch_reg, latch_next;
    logic             oe_n_reg, oe_n_next;

    always_comb
    begin
        phase_next  = phase_reg;
        column_next = column_reg;
        row_next    = row_reg;
        clock_next  = clock_reg;
        latch_next  = latch_reg;
        oe_n_next   = oe_n_reg;
        if (advance)
        begin
            unique case (phase_reg)
                hrsd_pkg::PH_DRIVE:
                begin
                    clock_next = 1'b0;
                    phase_next = hrsd_pkg::PH_CLK_HI;
                end
                hrsd_pkg::PH_CLK_HI:
                begin
                    clock_next = 1'b1;
                    phase_next = hrsd_pkg::PH_CLK_LO;
                end
                hrsd_pkg::PH_CLK_LO:
                begin
                    clock_next = 1'b0;
                    phase_next = hrsd_pkg::PH_HOLD;
                end
                hrsd_pkg::PH_HOLD:
                begin
                    if (column_reg == CW'(COLUMNS - 1))
                    begin
                        phase_next = hrsd_pkg::PH_LATCH_HI;
                    end
                    else
                    begin
                        column_next = column_reg + 1'b1;
                        phase_next  = hrsd_pkg::PH_DRIVE;
                    end
                end
                hrsd_pkg::PH_LATCH_HI:
                begin
                    latch_next = 1'b1;
                    phase_next = hrsd_pkg::PH_LATCH_LO;
                end
                hrsd_pkg::PH_LATCH_LO:
                begin
                    latch_next = 1'b0;
                    phase_next = hrsd_pkg::PH_OE_LO;
                end
                hrsd_pkg::PH_OE_LO:
                begin
                    oe_n_next  = 1'b0;
                    phase_next = hrsd_pkg::PH_OE_HI;
                end
                hrsd_pkg::PH_OE_HI:
                begin
                    oe_n_next   = 1'b1;
                    row_next    = (row_reg == RW'(HALF - 1)) ? '0 : row_reg + 1'b1;
                    column_next = '0;
                    phase_next  = hrsd_pkg::PH_DRIVE;
                end
                default:
                begin
                    phase_next = hrsd_pkg::PH_DRIVE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrsd_pkg::PH_DRIVE;
            column_reg <= '0;
            row_reg    <= '0;
            clock_reg  <= 1'b0;
            latch_reg  <= 1'b0;
            oe_n_reg   <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            clock_reg  <= clock_next;
            latch_reg  <= latch_next;
            oe_n_reg   <= oe_n_next;
        end
    end

    // colours of the current column are fetched on the drive step
    assign step.load_colours    = advance && (phase_reg == hrsd_pkg::PH_DRIVE);
    assign step.shift_clock     = clock_next;
    assign step.latch_strobe    = latch_next;
    assign step.output_enable_n = oe_n_next;
    assign step.row_address     = RA_W'(row_next);

    assign rd_row    = row_reg;
    assign rd_column = column_reg;

endmodule

// File: src/hub75_row_scan_driver.sv
// HUB75 1/16-scan panel driver with a one-bit-per-colour frame store. Each request transfer
// is either a pixel write or one refresh tick, and each gives exactly one result transfer
// carrying the pin levels after it. One request is taken per clock cycle unless the result
// path stalls. A request's scan step is held in the p1 register alongside the registered
// read of the frame-store banks, then moves to the output register (upper and lower
// panel half are read in the same cycle from separate banks).
// After reset the frame store is cleared one entry per cycle over all
// 2**($clog2(ROWS/2)+$clog2(COLUMNS)) entries (1024 at the defaults) before the first
// request is taken; the configuration port is always ready.
module hub75_row_scan_driver #(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 32
) (
    input logic        clk,
    input logic        rst_n,
    hrsd_cfg_if.sink   cfg,
    hrsd_in_if.sink    request,
    hrsd_out_if.source pins
);

    localparam int HALF = ROWS / 2;
    localparam int RW   = $clog2(HALF);
    localparam int CW   = $clog2(COLUMNS);
    localparam int AW   = RW + CW;
    localparam int CLW  = hrsd_pkg::COLOR_W;

    logic refresh_enable_reg;

    logic          clear_busy_reg;
    logic [AW-1:0] clear_addr_reg;

    logic accept;
    logic advance;
    logic pix_write;
    logic in_bottom;
    logic [5:0]    row_off;
    logic [RW-1:0] wr_row;
    logic [CW-1:0] wr_column;
    logic [AW-1:0] wr_addr;
    logic [CLW-1:0] wr_data;
    logic wr_top;
    logic wr_bottom;

    hrsd_pkg::scan_step_t scan;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_column;
    logic [CLW-1:0] top_rd;
    logic [CLW-1:0] bottom_rd;

    logic                 p1_valid_reg;
    hrsd_pkg::scan_step_t p1_reg;
    logic                 p1_move;

    logic                 out_valid_reg;
    logic [2*CLW-1:0]     out_colors_reg, out_colors_next;
    hrsd_pkg::scan_step_t out_step_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            refresh_enable_reg <= cfg.refresh_enable;
        end
    end

    // clearing pass over both banks after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == '1)
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    assign p1_move       = p1_valid_reg && (!out_valid_reg || pins.ready);
    assign request.ready = !clear_busy_reg && (!p1_valid_reg || p1_move);
    assign accept        = request.valid && request.ready;
    assign advance       = accept && (request.operation == hrsd_pkg::OP_TICK)
                           && refresh_enable_reg;

    // pixels outside the panel are dropped
    assign pix_write = accept && (request.operation == hrsd_pkg::OP_WRITE)
                       && (int'(request.pixel_row) < ROWS)
                       && (int'(request.pixel_column) < COLUMNS);
    assign in_bottom = int'(request.pixel_row) >= HALF;
    assign row_off   = in_bottom ? ({1'b0, request.pixel_row} - 6'(HALF))
                                 : {1'b0, request.pixel_row};
    assign wr_row    = RW'(row_off);
    assign wr_column = CW'(request.pixel_column);

    assign wr_addr   = clear_busy_reg ? clear_addr_reg : {wr_row, wr_column};
    assign wr_data   = clear_busy_reg ? '0
                     : {request.blue_on, request.green_on, request.red_on};
    assign wr_top    = clear_busy_reg || (pix_write && !in_bottom);
    assign wr_bottom = clear_busy_reg || (pix_write && in_bottom);

    hrsd_scan_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_scan_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .step      (scan),
        .rd_row    (rd_row),
        .rd_column (rd_column)
    );

    hrsd_frame_ram #(
        .AW (AW)
    ) u_top_ram (
        .clk     (clk),
        .wr_en   (wr_top),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (scan.load_colours),
        .rd_addr ({rd_row, rd_column}),
        .rd_data (top_rd)
    );

    hrsd_frame_ram #(
        .AW (AW)
    ) u_bottom_ram (
        .clk     (clk),
        .wr_en   (wr_bottom),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (scan.load_colours),
        .rd_addr ({rd_row, rd_column}),
        .rd_data (bottom_rd)
    );

    // read data stays put while p1 holds, since the next read needs the next transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            p1_valid_reg <= 1'b1;
        end
        else if (p1_move)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg <= scan;
        end
    end

    assign out_colors_next = p1_reg.load_colours ? {bottom_rd, top_rd} : out_colors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_colors_reg <= '0;
        end
        else if (p1_move)
        begin
            out_valid_reg  <= 1'b1;
            out_colors_reg <= out_colors_next;
        end
        else if (pins.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            out_step_reg <= p1_reg;
        end
    end

    assign pins.valid           = out_valid_reg;
    assign pins.red_top         = out_colors_reg[0];
    assign pins.green_top       = out_colors_reg[1];
    assign pins.blue_top        = out_colors_reg[2];
    assign pins.red_bottom      = out_colors_reg[CLW];
    assign pins.green_bottom    = out_colors_reg[CLW+1];
    assign pins.blue_bottom     = out_colors_reg[CLW+2];
    assign pins.shift_clock     = out_step_reg.shift_clock;
    assign pins.latch_strobe    = out_step_reg.latch_strobe;
    assign pins.output_enable_n = out_step_reg.output_enable_n;
    assign pins.row_address     = out_step_reg.row_address;

`ifndef SYNTHESIS
    a_drive_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && scan.load_colours) |=> (p1_valid_reg && p1_reg.load_colours))
        else $error("drive step did not reach the read stage");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !request.ready)
        else $error("request taken during frame store clear");

    a_clock_latch: assert property (@(posedge clk) disable iff (!rst_n)
        pins.valid |-> !(pins.shift_clock && pins.latch_strobe))
        else $error("shift clock and latch high together");
`endif

endmodule

// File: verif/tb_hub75_row_scan_driver.sv
module tb_hub75_row_scan_driver;

    localparam int COLUMNS        = 64;
    localparam int ROWS           = 32;
    localparam int HALF_ROWS      = ROWS / 2;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PRINT_CAP      = 40;

    typedef struct packed {
        logic       operation;
        logic [4:0] pixel_row;
        logic [5:0] pixel_column;
        logic       red_on;
        logic       green_on;
        logic       blue_on;
    } pixel_request_t;

    typedef struct packed {
        logic                            red_top;
        logic                            green_top;
        logic                            blue_top;
        logic                            red_bottom;
        logic                            green_bottom;
        logic                            blue_bottom;
        logic                            shift_clock;
        logic                            latch_strobe;
        logic                            output_enable_n;
        logic [hrsd_pkg::ROW_ADDR_W-1:0] row_address;
    } pin_levels_t;

    logic clk = 1'b0;
    logic rst_n;

    hrsd_cfg_if cfg_ch ();
    hrsd_in_if  req_ch ();
    hrsd_out_if pin_ch ();

    hub75_row_scan_driver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .request (req_ch),
        .pins    (pin_ch)
    );

    // panel model state
    logic [hrsd_pkg::COLOR_W-1:0] frame_bits [ROWS][COLUMNS];
    hrsd_pkg::phase_t             scan_phase;
    int unsigned                  scan_row;
    int unsigned                  scan_column;
    pin_levels_t                  pin_now;
    logic                         refresh_on;

    pin_levels_t expected_pins [$];

    int sender_idle_pct;
    int sink_idle_pct;
    logic sink_hold = 1'b0;

    int mismatches;
    int n_writes;
    int n_ticks;
    int n_results;
    int n_latches;
    int n_row_wraps;
    int n_cfg_writes;

    always #10 clk = ~clk;

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic reset_panel_model();
        foreach (frame_bits[r, c])
            frame_bits[r][c] = '0;
        scan_phase  = hrsd_pkg::PH_DRIVE;
        scan_row    = 0;
        scan_column = 0;
        pin_now     = '0;
        pin_now.output_enable_n = 1'b1;
        refresh_on  = 1'b0;
    endtask

    // one refresh step of the panel sequence
    task automatic step_scan();
        logic [hrsd_pkg::COLOR_W-1:0] top;
        logic [hrsd_pkg::COLOR_W-1:0] bot;
        case (scan_phase)
            hrsd_pkg::PH_DRIVE:
            begin
                top = frame_bits[scan_row][scan_column];
                bot = frame_bits[scan_row + HALF_ROWS][scan_column];
                pin_now.red_top      = top[0];
                pin_now.green_top    = top[1];
                pin_now.blue_top     = top[2];
                pin_now.red_bottom   = bot[0];
                pin_now.green_bottom = bot[1];
                pin_now.blue_bottom  = bot[2];
                pin_now.shift_clock  = 1'b0;
                scan_phase = hrsd_pkg::PH_CLK_HI;
            end
            hrsd_pkg::PH_CLK_HI:
            begin
                pin_now.shift_clock = 1'b1;
                scan_phase = hrsd_pkg::PH_CLK_LO;
            end
            hrsd_pkg::PH_CLK_LO:
            begin
                pin_now.shift_clock = 1'b0;
                scan_phase = hrsd_pkg::PH_HOLD;
            end
            hrsd_pkg::PH_HOLD:
            begin
                if (scan_column + 1 < COLUMNS)
                begin
                    scan_column++;
                    scan_phase = hrsd_pkg::PH_DRIVE;
                end
                else
                    scan_phase = hrsd_pkg::PH_LATCH_HI;
            end
            hrsd_pkg::PH_LATCH_HI:
            begin
                pin_now.latch_strobe = 1'b1;
                n_latches++;
                scan_phase = hrsd_pkg::PH_LATCH_LO;
            end
            hrsd_pkg::PH_LATCH_LO:
            begin
                pin_now.latch_strobe = 1'b0;
                scan_phase = hrsd_pkg::PH_OE_LO;
            end
            hrsd_pkg::PH_OE_LO:
            begin
                pin_now.output_enable_n = 1'b0;
                scan_phase = hrsd_pkg::PH_OE_HI;
            end
            default:
            begin
                pin_now.output_enable_n = 1'b1;
                scan_row = (scan_row + 1) % HALF_ROWS;
                if (scan_row == 0)
                    n_row_wraps++;
                scan_column = 0;
                scan_phase  = hrsd_pkg::PH_DRIVE;
            end
        endcase
        pin_now.row_address = hrsd_pkg::ROW_ADDR_W'(scan_row);
    endtask

    // apply one accepted request to the model and queue the pins it leaves
    task automatic predict_pins(input pixel_request_t item);
        if (item.operation == hrsd_pkg::OP_WRITE)
        begin
            n_writes++;
            if (item.pixel_row < ROWS && item.pixel_column < COLUMNS)
                frame_bits[item.pixel_row][item.pixel_column] =
                    {item.blue_on, item.green_on, item.red_on};
        end
        else
        begin
            n_ticks++;
            if (refresh_on)
                step_scan();
        end
        expected_pins.push_back(pin_now);
    endtask

    task automatic send_request(input pixel_request_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= item.operation;
        req_ch.pixel_row    <= item.pixel_row;
        req_ch.pixel_column <= item.pixel_column;
        req_ch.red_on       <= item.red_on;
        req_ch.green_on     <= item.green_on;
        req_ch.blue_on      <= item.blue_on;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_pins(item);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_refresh_enable(input logic enable);
        wait_drained();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.refresh_enable <= enable;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        refresh_on = enable;
        n_cfg_writes++;
    endtask

    task automatic set_idling(input int sender_pct, input int sink_pct);
        sender_idle_pct = sender_pct;
        sink_idle_pct   = sink_pct;
    endtask

    function automatic pixel_request_t pixel_write(input int r, input int c,
                                                   input logic [2:0] rgb);
        pixel_request_t item;
        item.operation    = hrsd_pkg::OP_WRITE;
        item.pixel_row    = 5'(r);
        item.pixel_column = 6'(c);
        item.red_on       = rgb[0];
        item.green_on     = rgb[1];
        item.blue_on      = rgb[2];
        return item;
    endfunction

    function automatic pixel_request_t refresh_tick();
        pixel_request_t item;
        item = '0;
        item.operation = hrsd_pkg::OP_TICK;
        return item;
    endfunction

    function automatic pixel_request_t random_request(input int tick_pct);
        pixel_request_t item;
        item.operation    = ($urandom_range(99) < tick_pct) ? hrsd_pkg::OP_TICK
                                                            : hrsd_pkg::OP_WRITE;
        item.pixel_row    = 5'($urandom);
        item.pixel_column = 6'($urandom);
        item.red_on       = 1'($urandom);
        item.green_on     = 1'($urandom);
        item.blue_on      = 1'($urandom);
        return item;
    endfunction

    // ticks with refresh off must leave the idle pin levels alone
    task automatic test_idle_after_reset();
        set_idling(0, 0);
        write_refresh_enable(1'b0);
        send_request(refresh_tick());
        send_request(refresh_tick());
        send_request(pixel_write(5, 9, 3'b111));
    endtask

    // two opposite corners of the panel and both halves of the first scan row
    task automatic test_pixel_extremes();
        send_request(pixel_write(0, 0, 3'b111));
        send_request(pixel_write(ROWS - 1, COLUMNS - 1, 3'b111));
        send_request(pixel_write(HALF_ROWS - 1, COLUMNS - 1, 3'b101));
        send_request(pixel_write(HALF_ROWS, 0, 3'b010));
        send_request(pixel_write(0, 1, 3'b100));
        send_request(pixel_write(HALF_ROWS, 1, 3'b011));
        write_refresh_enable(1'b1);
        repeat (8)
            send_request(refresh_tick());
    endtask

    // a write after the colour fetch must not reach the pins until the next visit
    task automatic test_late_write();
        send_request(refresh_tick());
        send_request(refresh_tick());
        send_request(pixel_write(0, 2, 3'b111));
        send_request(pixel_write(0, 0, 3'b000));
        write_refresh_enable(1'b0);
        send_request(refresh_tick());
        send_request(refresh_tick());
        write_refresh_enable(1'b1);
        send_request(refresh_tick());
        send_request(refresh_tick());
    endtask

    task automatic test_random_scan(input int sender_pct, input int sink_pct, input int count);
        set_idling(sender_pct, sink_pct);
        write_refresh_enable(1'b1);
        repeat (count)
            send_request(random_request(88));
    endtask

    task automatic test_refresh_toggle();
        set_idling(36, 83);
        write_refresh_enable(1'b0);
        repeat (150)
            send_request(random_request(50));
        write_refresh_enable(1'b1);
    endtask

    // long receiver stall while requests keep coming, so the input side backs up
    task automatic test_backpressure();
        set_idling(0, 0);
        fork
            begin
                @(negedge clk);
                sink_hold = 1'b1;
                repeat (HOLDOFF_CYCLES)
                    @(negedge clk);
                sink_hold = 1'b0;
            end
        join_none
        repeat (80)
            send_request(random_request(90));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pin_ch.ready <= 1'b0;
        else if (sink_hold)
            pin_ch.ready <= 1'b0;
        else
            pin_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        pin_levels_t want;
        pin_levels_t got;
        if (rst_n && pin_ch.valid === 1'b1 && pin_ch.ready === 1'b1)
        begin
            if (expected_pins.size() == 0)
                report_mismatch($sformatf("result transfer %0d with nothing pending",
                                          n_results));
            else
            begin
                want = expected_pins.pop_front();
                got.red_top         = pin_ch.red_top;
                got.green_top       = pin_ch.green_top;
                got.blue_top        = pin_ch.blue_top;
                got.red_bottom      = pin_ch.red_bottom;
                got.green_bottom    = pin_ch.green_bottom;
                got.blue_bottom     = pin_ch.blue_bottom;
                got.shift_clock     = pin_ch.shift_clock;
                got.latch_strobe    = pin_ch.latch_strobe;
                got.output_enable_n = pin_ch.output_enable_n;
                got.row_address     = pin_ch.row_address;
                if (got !== want)
                    report_mismatch($sformatf("result %0d pins got %h expected %h",
                                              n_results, got, want));
            end
            n_results++;
        end
    end

    initial begin
        rst_n                 = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.refresh_enable = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.operation      = hrsd_pkg::OP_WRITE;
        req_ch.pixel_row      = '0;
        req_ch.pixel_column   = '0;
        req_ch.red_on         = 1'b0;
        req_ch.green_on       = 1'b0;
        req_ch.blue_on        = 1'b0;
        mismatches            = 0;
        n_writes              = 0;
        n_ticks               = 0;
        n_results             = 0;
        n_latches             = 0;
        n_row_wraps           = 0;
        n_cfg_writes          = 0;
        set_idling(0, 0);
        reset_panel_model();

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_pixel_extremes();
        test_late_write();
        test_random_scan(36, 83, 500);
        test_random_scan(83, 36, 500);
        test_refresh_toggle();
        test_backpressure();
        test_random_scan(0, 0, 500);

        wait_drained();
        repeat (8)
            @(posedge clk);

        $display("covered %0d pixel writes and %0d refresh ticks, %0d results checked",
                 n_writes, n_ticks, n_results);
        $display("scan reached row %0d after %0d frame wraps, %0d latch pulses, %0d %s",
                 scan_row, n_row_wraps, n_latches, n_cfg_writes, "enable register writes");
        if (mismatches == 0 && expected_pins.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
